// ----- sv/sh_probe_grid_trilinear_sampler_defines.svh -----
// Assertion macros shared by the probe grid sampler.
// Needs a clock named i_clk and an active-low reset named i_rst_n in the using scope.
`ifndef SH_PROBE_GRID_TRILINEAR_SAMPLER_DEFINES_SVH
`define SH_PROBE_GRID_TRILINEAR_SAMPLER_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define SHG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sampler assertion failed");

// Condition implies consequence in the next cycle.
`define SHG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sampler assertion failed");

`endif

// ----- sv/shg_pkg.sv -----
// Package of the probe grid sampler: grid sizes, number formats, SH constants,
// controller states and the command and status structs. Depends on nothing.
package shg_pkg;

    localparam int RES_X    = 8;
    localparam int RES_Y    = 8;
    localparam int RES_Z    = 8;
    localparam int SH_TERMS = 9;
    localparam int PROBES   = RES_X * RES_Y * RES_Z;
    localparam int DEPTH    = PROBES * SH_TERMS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int RES_MAX  = (RES_X > RES_Y) ? ((RES_X > RES_Z) ? RES_X : RES_Z)
                                              : ((RES_Y > RES_Z) ? RES_Y : RES_Z);
    localparam int CRD_W    = (RES_MAX > 1) ? $clog2(RES_MAX) : 1;
    localparam int AXIS_RES [3] = '{RES_X, RES_Y, RES_Z};

    localparam int PN_W      = 9;
    localparam int TERM_W    = 4;
    localparam int COEF_W    = 32;
    localparam int POS_W     = 32;
    localparam int DIR_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int BASIS_W   = 20;
    localparam int PROD_W    = 52;
    localparam int ACC_W     = 56;
    localparam int VAL_W     = 40;
    localparam int DIV_BITS  = 48;
    localparam int BIT_W     = 6;
    localparam int AXIS_W    = 2;
    localparam int CORNERS   = 8;
    localparam int CORNER_W  = 3;
    localparam int STEP_W    = 3;
    localparam int LERP_LAST = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_Z   = 3'd5;

    // SH basis constants in Q.16.
    localparam logic signed [17:0] K_C0 = 18'sd18487;
    localparam logic signed [17:0] K_C1 = 18'sd32021;
    localparam logic signed [17:0] K_C2 = 18'sd71601;
    localparam logic signed [17:0] K_C3 = 18'sd20670;
    localparam logic signed [17:0] K_C4 = 18'sd35801;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_DIV_STORE,
        S_CORNER,
        S_MAC,
        S_DRAIN,
        S_PUSH,
        S_LERP_MUL,
        S_LERP_ADD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                clr_we;
        logic [ADDR_W-1:0]   clr_addr;
        logic                coef_we;
        logic                sample_load;
        logic                div_load;
        logic                div_step;
        logic                div_store;
        logic [AXIS_W-1:0]   axis;
        logic                corner_load;
        logic [CORNER_W-1:0] corner;
        logic                acc_clr;
        logic                mac_issue;
        logic [TERM_W-1:0]   term;
        logic                push;
        logic                lerp_mul;
        logic                lerp_add;
        logic [STEP_W-1:0]   step;
        logic                out_load;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_status;

endpackage

// ----- sv/sh_probe_grid_trilinear_sampler.sv -----
// Probe grid sampler: an 8 x 8 x 8 grid of probes with nine SH RGB coefficients each.
// Requests arrive on a valid/ready input channel. A write request (opcode 0) stores one
// coefficient triple in the cycle it is accepted and produces no result. A sample
// request (opcode 1) produces one RGB irradiance result on the valid/ready output.
// Configuration (grid origin and cell size per axis) is written through a plain write
// port with an index; it should only be changed while no sample is in flight.
// A sample passes from acceptance to the output register through three 48-bit
// divisions on one shared restoring divider, then eight corners of nine memory reads
// each through a three-channel MAC pipeline, then seven blending steps of a multiply
// and an add. The next request is accepted only once the current sample has moved
// into the output register.
// After reset the coefficient memories, all 4608 words, are cleared one word a cycle,
// during which no request is accepted; configuration writes are taken at any time.
// A result waits in the output register while the receiver stalls; the block keeps
// accepting requests, but a new sample holds at its last step until the register is free.
// Depends on shg_pkg, shg_ctrl, shg_datapath and the assertion macro header.
`include "sh_probe_grid_trilinear_sampler_defines.svh"

module sh_probe_grid_trilinear_sampler
    import shg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_opcode,
    input  logic [PN_W-1:0]          i_probe_number,
    input  logic [TERM_W-1:0]        i_band_term,
    input  logic signed [COEF_W-1:0] i_coef_red,
    input  logic signed [COEF_W-1:0] i_coef_green,
    input  logic signed [COEF_W-1:0] i_coef_blue,
    input  logic signed [POS_W-1:0]  i_sample_x,
    input  logic signed [POS_W-1:0]  i_sample_y,
    input  logic signed [POS_W-1:0]  i_sample_z,
    input  logic signed [DIR_W-1:0]  i_dir_x,
    input  logic signed [DIR_W-1:0]  i_dir_y,
    input  logic signed [DIR_W-1:0]  i_dir_z,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [COEF_W-1:0] o_light_red,
    output logic signed [COEF_W-1:0] o_light_green,
    output logic signed [COEF_W-1:0] o_light_blue,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // The controller sequences every phase; the datapath only follows its commands.
    shg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    shg_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_probe_number (i_probe_number),
        .i_band_term    (i_band_term),
        .i_coef_red     (i_coef_red),
        .i_coef_green   (i_coef_green),
        .i_coef_blue    (i_coef_blue),
        .i_sample_x     (i_sample_x),
        .i_sample_y     (i_sample_y),
        .i_sample_z     (i_sample_z),
        .i_dir_x        (i_dir_x),
        .i_dir_y        (i_dir_y),
        .i_dir_z        (i_dir_z),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_light_red    (o_light_red),
        .o_light_green  (o_light_green),
        .o_light_blue   (o_light_blue)
    );

    // No request is taken while the memories are being cleared.
    `SHG_ASSERT_IMP(a_no_ready_in_clear, cmd.clr_we, !o_in_ready)
    // A coefficient write never collides with the clearing pass.
    `SHG_ASSERT_IMP(a_write_not_in_clear, cmd.coef_we, !cmd.clr_we)
    // An accepted sample makes the block busy in the next cycle.
    `SHG_ASSERT_NXT(a_busy_after_sample, i_in_valid && o_in_ready && i_opcode == OP_SAMPLE,
                    !o_in_ready)
    // A result is loaded only into an empty output register.
    `SHG_ASSERT_IMP(a_load_when_empty, cmd.out_load, !status.out_full)
    // Output valid rises only after a result load.
    `SHG_ASSERT_IMP(a_valid_from_load, $rose(o_out_valid), $past(cmd.out_load))

endmodule

// ----- sv/shg_ctrl.sv -----
// Sequencer of the probe grid sampler: clearing pass, divisions, corner MACs, blending.
// Depends on shg_pkg.
module shg_ctrl
    import shg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_opcode,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic [ADDR_W-1:0]   r_cnt;
    logic [AXIS_W-1:0]   r_axis;
    logic [BIT_W-1:0]    r_bit;
    logic [CORNER_W-1:0] r_corner;
    logic [TERM_W-1:0]   r_term;
    logic                r_drain;
    logic [STEP_W-1:0]   r_step;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (r_cnt == ADDR_W'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:      if (i_in_valid && i_opcode == OP_SAMPLE) n_state = S_DIV_LOAD;
            S_DIV_LOAD:  n_state = S_DIV_RUN;
            S_DIV_RUN:   if (r_bit == BIT_W'(DIV_BITS - 1)) n_state = S_DIV_STORE;
            S_DIV_STORE: n_state = (r_axis == AXIS_W'(2)) ? S_CORNER : S_DIV_LOAD;
            S_CORNER:    n_state = S_MAC;
            S_MAC:       if (r_term == TERM_W'(SH_TERMS - 1)) n_state = S_DRAIN;
            S_DRAIN:     if (r_drain) n_state = S_PUSH;
            S_PUSH:      n_state = (r_corner == CORNER_W'(CORNERS - 1)) ? S_LERP_MUL : S_CORNER;
            S_LERP_MUL:  n_state = S_LERP_ADD;
            S_LERP_ADD:  n_state = (r_step == STEP_W'(LERP_LAST)) ? S_OUT : S_LERP_MUL;
            S_OUT:       if (!i_status.out_full) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.clr_addr    = r_cnt;
        o_cmd.axis        = r_axis;
        o_cmd.corner      = r_corner;
        o_cmd.term        = r_term;
        o_cmd.step        = r_step;
        o_cmd.clr_we      = (r_state == S_CLEAR);
        o_in_ready        = (r_state == S_IDLE);
        o_cmd.coef_we     = (r_state == S_IDLE) && i_in_valid && (i_opcode == OP_WRITE);
        o_cmd.sample_load = (r_state == S_IDLE) && i_in_valid && (i_opcode == OP_SAMPLE);
        o_cmd.div_load    = (r_state == S_DIV_LOAD);
        o_cmd.div_step    = (r_state == S_DIV_RUN);
        o_cmd.div_store   = (r_state == S_DIV_STORE);
        o_cmd.corner_load = (r_state == S_CORNER);
        o_cmd.acc_clr     = (r_state == S_CORNER);
        o_cmd.mac_issue   = (r_state == S_MAC);
        o_cmd.push        = (r_state == S_PUSH);
        o_cmd.lerp_mul    = (r_state == S_LERP_MUL);
        o_cmd.lerp_add    = (r_state == S_LERP_ADD);
        o_cmd.out_load    = (r_state == S_OUT) && !i_status.out_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_axis   <= '0;
            r_bit    <= '0;
            r_corner <= '0;
            r_term   <= '0;
            r_drain  <= 1'b0;
            r_step   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + ADDR_W'(1);
                end
                S_IDLE: begin
                    r_axis   <= '0;
                    r_corner <= '0;
                    r_step   <= '0;
                end
                S_DIV_LOAD:  r_bit <= '0;
                S_DIV_RUN:   r_bit <= r_bit + BIT_W'(1);
                S_DIV_STORE: r_axis <= r_axis + AXIS_W'(1);
                S_CORNER: begin
                    r_term  <= '0;
                    r_drain <= 1'b0;
                end
                S_MAC:      r_term <= r_term + TERM_W'(1);
                S_DRAIN:    r_drain <= ~r_drain;
                S_PUSH:     r_corner <= r_corner + CORNER_W'(1);
                S_LERP_ADD: r_step <= r_step + STEP_W'(1);
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- sv/shg_datapath.sv -----
// Datapath of the probe grid sampler: configuration, coefficient memories, divider,
// SH basis, per-channel MAC, blending queue and output register. Depends on shg_pkg.
module shg_datapath
    import shg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic [PN_W-1:0]          i_probe_number,
    input  logic [TERM_W-1:0]        i_band_term,
    input  logic signed [COEF_W-1:0] i_coef_red,
    input  logic signed [COEF_W-1:0] i_coef_green,
    input  logic signed [COEF_W-1:0] i_coef_blue,
    input  logic signed [POS_W-1:0]  i_sample_x,
    input  logic signed [POS_W-1:0]  i_sample_y,
    input  logic signed [POS_W-1:0]  i_sample_z,
    input  logic signed [DIR_W-1:0]  i_dir_x,
    input  logic signed [DIR_W-1:0]  i_dir_y,
    input  logic signed [DIR_W-1:0]  i_dir_z,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [COEF_W-1:0] o_light_red,
    output logic signed [COEF_W-1:0] o_light_green,
    output logic signed [COEF_W-1:0] o_light_blue
);

    localparam logic signed [VAL_W-1:0] SAT_MAX = VAL_W'(2147483647);
    localparam logic signed [VAL_W-1:0] SAT_MIN = -SAT_MAX - VAL_W'(1);

    function automatic logic [CRD_W-1:0] clamp_idx(input logic signed [33:0] v,
                                                   input int hi);
        logic [CRD_W-1:0] r;
        if (v < 34'sd0) r = '0;
        else if (v > 34'(hi - 1)) r = CRD_W'(hi - 1);
        else r = v[CRD_W-1:0];
        return r;
    endfunction

    // Configuration registers.
    logic signed [POS_W-1:0] r_org  [3];
    logic signed [POS_W-1:0] r_cell [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_org[a]  <= '0;
                r_cell[a] <= POS_W'(65536);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X: r_org[0]  <= i_cfg_data;
                CFG_ORIGIN_Y: r_org[1]  <= i_cfg_data;
                CFG_ORIGIN_Z: r_org[2]  <= i_cfg_data;
                CFG_CELL_X:   r_cell[0] <= i_cfg_data;
                CFG_CELL_Y:   r_cell[1] <= i_cfg_data;
                CFG_CELL_Z:   r_cell[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Latched sample request.
    logic signed [POS_W-1:0] r_pos [3];
    logic signed [DIR_W-1:0] r_dir [3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.sample_load) begin
            r_pos[0] <= i_sample_x;
            r_pos[1] <= i_sample_y;
            r_pos[2] <= i_sample_z;
            r_dir[0] <= i_dir_x;
            r_dir[1] <= i_dir_y;
            r_dir[2] <= i_dir_z;
        end
    end

    // SH basis, two register stages fed from the latched normal.
    logic signed [31:0]        r_pxy, r_pyz, r_pxz, r_pdiff;
    logic signed [33:0]        r_pz3;
    logic signed [BASIS_W-1:0] r_basis [SH_TERMS];
    logic signed [33:0]        m1x, m1y, m1z;
    logic signed [51:0]        m4, m5, m6, m7, m8;

    always_comb begin
        m1y = 34'(K_C1) * 34'(r_dir[1]);
        m1z = 34'(K_C1) * 34'(r_dir[2]);
        m1x = 34'(K_C1) * 34'(r_dir[0]);
        m4  = 52'(K_C2) * 52'(r_pxy);
        m5  = 52'(K_C2) * 52'(r_pyz);
        m6  = 52'(K_C3) * 52'(r_pz3);
        m7  = 52'(K_C2) * 52'(r_pxz);
        m8  = 52'(K_C4) * 52'(r_pdiff);
    end

    always_ff @(posedge i_clk) begin
        r_pxy   <= 32'(r_dir[0]) * 32'(r_dir[1]);
        r_pyz   <= 32'(r_dir[1]) * 32'(r_dir[2]);
        r_pxz   <= 32'(r_dir[0]) * 32'(r_dir[2]);
        r_pdiff <= 32'(r_dir[0]) * 32'(r_dir[0]) - 32'(r_dir[1]) * 32'(r_dir[1]);
        r_pz3   <= 34'sd3 * 34'(r_dir[2]) * 34'(r_dir[2]) - 34'sd268435456;
        r_basis[0] <= BASIS_W'(K_C0);
        r_basis[1] <= BASIS_W'((m1y + 34'sd8192) >>> 14);
        r_basis[2] <= BASIS_W'((m1z + 34'sd8192) >>> 14);
        r_basis[3] <= BASIS_W'((m1x + 34'sd8192) >>> 14);
        r_basis[4] <= BASIS_W'((m4 + 52'sd134217728) >>> 28);
        r_basis[5] <= BASIS_W'((m5 + 52'sd134217728) >>> 28);
        r_basis[6] <= BASIS_W'((m6 + 52'sd134217728) >>> 28);
        r_basis[7] <= BASIS_W'((m7 + 52'sd134217728) >>> 28);
        r_basis[8] <= BASIS_W'((m8 + 52'sd134217728) >>> 28);
    end

    // Restoring divider, one quotient bit per cycle, shared by the three axes.
    logic [DIV_BITS-1:0]     r_num;
    logic [30:0]             r_rem, r_dvs;
    logic                    r_neg;
    logic signed [32:0]      diff;
    logic [48:0]             num_ext, g;
    logic [31:0]             rem_sh, rem_sub;
    logic                    ge;
    logic signed [POS_W-1:0] cell_sel;
    logic signed [33:0]      base;
    logic [CRD_W-1:0]        r_lo [3];
    logic [CRD_W-1:0]        r_hi [3];
    logic [FRAC_W-1:0]       r_frac [3];

    always_comb begin
        diff     = 33'(r_pos[i_cmd.axis]) - 33'(r_org[i_cmd.axis]);
        num_ext  = {diff, 16'b0};
        cell_sel = r_cell[i_cmd.axis];
        rem_sh   = {r_rem, r_num[DIV_BITS-1]};
        rem_sub  = rem_sh - {1'b0, r_dvs};
        ge       = (rem_sh >= {1'b0, r_dvs});
        g        = r_neg ? ~{1'b0, r_num} : {1'b0, r_num};
        base     = 34'($signed(g[48:16]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_neg <= diff[32];
            r_num <= diff[32] ? ~num_ext[DIV_BITS-1:0] : num_ext[DIV_BITS-1:0];
            r_rem <= '0;
            r_dvs <= (cell_sel > 32'sd0) ? cell_sel[30:0] : 31'd65536;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? rem_sub[30:0] : rem_sh[30:0];
            r_num <= {r_num[DIV_BITS-2:0], ge};
        end
        if (i_cmd.div_store) begin
            r_lo[i_cmd.axis]   <= clamp_idx(base, AXIS_RES[i_cmd.axis]);
            r_hi[i_cmd.axis]   <= clamp_idx(base + 34'sd1, AXIS_RES[i_cmd.axis]);
            r_frac[i_cmd.axis] <= g[FRAC_W-1:0];
        end
    end

    // Coefficient memories, one per channel, word address probe * terms + term.
    logic signed [COEF_W-1:0] mem_r [DEPTH];
    logic signed [COEF_W-1:0] mem_g [DEPTH];
    logic signed [COEF_W-1:0] mem_b [DEPTH];
    logic [ADDR_W-1:0]        r_row, rd_addr, wr_addr, mem_waddr;
    logic                     wr_ok, mem_we;
    logic [CRD_W-1:0]         px, py, pz;
    logic signed [COEF_W-1:0] r_rd [3];

    always_comb begin
        wr_ok     = i_cmd.coef_we && (int'(i_probe_number) < PROBES)
                    && (int'(i_band_term) < SH_TERMS);
        wr_addr   = ADDR_W'(int'(i_probe_number) * SH_TERMS + int'(i_band_term));
        mem_we    = i_cmd.clr_we || wr_ok;
        mem_waddr = i_cmd.clr_we ? i_cmd.clr_addr : wr_addr;
        rd_addr   = r_row + ADDR_W'(i_cmd.term);
        px        = i_cmd.corner[0] ? r_hi[0] : r_lo[0];
        py        = i_cmd.corner[1] ? r_hi[1] : r_lo[1];
        pz        = i_cmd.corner[2] ? r_hi[2] : r_lo[2];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_r[mem_waddr] <= i_cmd.clr_we ? '0 : i_coef_red;
            mem_g[mem_waddr] <= i_cmd.clr_we ? '0 : i_coef_green;
            mem_b[mem_waddr] <= i_cmd.clr_we ? '0 : i_coef_blue;
        end
        r_rd[0] <= mem_r[rd_addr];
        r_rd[1] <= mem_g[rd_addr];
        r_rd[2] <= mem_b[rd_addr];
        if (i_cmd.corner_load) begin
            r_row <= ADDR_W'(((int'(pz) * RES_Y + int'(py)) * RES_X + int'(px)) * SH_TERMS);
        end
    end

    // MAC pipeline: read, multiply, accumulate.
    logic                     r_rd_v, r_mul_v;
    logic [TERM_W-1:0]        r_rd_term;
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [ACC_W-1:0]  r_acc [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
        end else begin
            r_rd_v  <= i_cmd.mac_issue;
            r_mul_v <= r_rd_v;
        end
        r_rd_term <= i_cmd.term;
        for (int c = 0; c < 3; c++) begin
            r_prod[c] <= PROD_W'(r_rd[c]) * PROD_W'(r_basis[r_rd_term]);
            if (i_cmd.acc_clr) r_acc[c] <= '0;
            else if (r_mul_v) r_acc[c] <= r_acc[c] + ACC_W'(r_prod[c]);
        end
    end

    // Blending queue: corners shift in at the tail, each blend takes the two head
    // entries and writes its result behind the entries still waiting.
    logic signed [VAL_W-1:0] r_q [CORNERS][3];
    logic signed [57:0]      r_lp [3];
    logic signed [VAL_W:0]   ld [3];
    logic signed [57:0]      lrnd [3];
    logic [FRAC_W-1:0]       t_sel;
    logic [STEP_W-1:0]       wr_slot;

    always_comb begin
        if (i_cmd.step < STEP_W'(4)) t_sel = r_frac[0];
        else if (i_cmd.step < STEP_W'(6)) t_sel = r_frac[1];
        else t_sel = r_frac[2];
        wr_slot = STEP_W'(LERP_LAST) - i_cmd.step;
        for (int c = 0; c < 3; c++) begin
            ld[c]   = (VAL_W + 1)'(r_q[1][c]) - (VAL_W + 1)'(r_q[0][c]);
            lrnd[c] = (r_lp[c] + 58'sd32768) >>> 16;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.lerp_mul) begin
                r_lp[c] <= 58'(ld[c]) * 58'($signed({1'b0, t_sel}));
            end
            if (i_cmd.push) begin
                for (int i = 0; i < CORNERS - 1; i++) r_q[i][c] <= r_q[i + 1][c];
                r_q[CORNERS-1][c] <= VAL_W'((r_acc[c] + 56'sd32768) >>> 16);
            end else if (i_cmd.lerp_add) begin
                for (int i = 0; i < CORNERS - 2; i++) begin
                    if (STEP_W'(i) != wr_slot) r_q[i][c] <= r_q[i + 2][c];
                end
                r_q[wr_slot][c] <= r_q[0][c] + VAL_W'(lrnd[c]);
            end
        end
    end

    // Output register with saturation.
    logic                     r_out_valid;
    logic signed [COEF_W-1:0] r_light [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            for (int c = 0; c < 3; c++) begin
                if (r_q[0][c] > SAT_MAX) r_light[c] <= SAT_MAX[COEF_W-1:0];
                else if (r_q[0][c] < SAT_MIN) r_light[c] <= SAT_MIN[COEF_W-1:0];
                else r_light[c] <= r_q[0][c][COEF_W-1:0];
            end
        end
    end

    assign o_status.out_full = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_light_red       = r_light[0];
    assign o_light_green     = r_light[1];
    assign o_light_blue      = r_light[2];

endmodule

// ----- tb/sh_probe_grid_trilinear_sampler_tb.sv -----
// Self-checking testbench for the SH probe grid sampler: coefficient writes and
// trilinear irradiance samples are predicted by a scoreboard class and compared.
// Depends on shg_pkg and the sh_probe_grid_trilinear_sampler RTL.
`timescale 1ns / 1ps

module sh_probe_grid_trilinear_sampler_tb;
    import shg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_CYCLES    = 3000;
    localparam int PHASE_ITEMS    = 375;

    // One request as it appears on the input channel.
    typedef struct {
        logic                     op;
        logic [PN_W-1:0]          pn;
        logic [TERM_W-1:0]        term;
        logic signed [COEF_W-1:0] coef [3];
        logic signed [POS_W-1:0]  pos [3];
        logic signed [DIR_W-1:0]  dir [3];
    } t_grid_req;

    typedef struct {
        logic signed [COEF_W-1:0] rgb [3];
    } t_light;

    // Irradiance predictor with its own copy of the probe store and grid setup.
    // note_request() is called for every accepted request, check_light() for
    // every accepted result.
    class t_irradiance_book;
        int     probe_coef [PROBES*SH_TERMS][3];
        longint origin [3];
        longint cell_size [3];
        t_light pending [$];
        int     errors;
        int     writes;
        int     samples;
        int     checked;

        function new();
            foreach (probe_coef[i, c]) probe_coef[i][c] = 0;
            foreach (origin[a]) begin
                origin[a]    = 0;
                cell_size[a] = 65536;
            end
            errors  = 0;
            writes  = 0;
            samples = 0;
            checked = 0;
        endfunction

        // Round half up, then drop n fraction bits.
        function longint rnd(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        function longint floor_div(longint num, longint d);
            if (num >= 0) return num / d;
            return -((-num - 1) / d) - 1;
        endfunction

        function longint lerp(longint a, longint b, longint t);
            return a + rnd((b - a) * t, 16);
        endfunction

        function void set_grid(int idx, logic [CFG_W-1:0] data);
            if (idx < 3) origin[idx] = longint'($signed(data));
            else cell_size[idx-3] = longint'($signed(data));
        endfunction

        function void note_request(t_grid_req r);
            longint basis [SH_TERMS];
            longint nx, ny, nz, gpos, csize, acc;
            longint base [3];
            longint frac [3];
            longint val [8][3];
            longint blend [4];
            longint y0, y1, res;
            int     px, py, pz, probe;
            t_light lt;
            if (r.op == OP_WRITE) begin
                writes++;
                // Out-of-range terms or probes leave the store untouched.
                if (r.pn < PROBES && r.term < SH_TERMS)
                    for (int c = 0; c < 3; c++)
                        probe_coef[r.pn*SH_TERMS + r.term][c] = r.coef[c];
                return;
            end
            samples++;
            nx = longint'(r.dir[0]);
            ny = longint'(r.dir[1]);
            nz = longint'(r.dir[2]);
            basis[0] = K_C0;
            basis[1] = rnd(K_C1 * ny, 14);
            basis[2] = rnd(K_C1 * nz, 14);
            basis[3] = rnd(K_C1 * nx, 14);
            basis[4] = rnd(K_C2 * (nx * ny), 28);
            basis[5] = rnd(K_C2 * (ny * nz), 28);
            basis[6] = rnd(K_C3 * (3 * nz * nz - (longint'(1) <<< 28)), 28);
            basis[7] = rnd(K_C2 * (nx * nz), 28);
            basis[8] = rnd(K_C4 * (nx * nx - ny * ny), 28);
            for (int a = 0; a < 3; a++) begin
                csize   = (cell_size[a] > 0) ? cell_size[a] : 65536;
                gpos    = floor_div((longint'(r.pos[a]) - origin[a]) * 65536, csize);
                base[a] = gpos >>> 16;
                frac[a] = gpos & 65535;
            end
            for (int i = 0; i < 8; i++) begin
                // Corners beyond the grid repeat the edge probes.
                px = (base[0] + (i & 1) < 0) ? 0 :
                     (base[0] + (i & 1) > RES_X - 1) ? RES_X - 1 : int'(base[0] + (i & 1));
                py = (base[1] + ((i >> 1) & 1) < 0) ? 0 :
                     (base[1] + ((i >> 1) & 1) > RES_Y - 1) ? RES_Y - 1 :
                     int'(base[1] + ((i >> 1) & 1));
                pz = (base[2] + ((i >> 2) & 1) < 0) ? 0 :
                     (base[2] + ((i >> 2) & 1) > RES_Z - 1) ? RES_Z - 1 :
                     int'(base[2] + ((i >> 2) & 1));
                probe = (pz * RES_Y + py) * RES_X + px;
                for (int c = 0; c < 3; c++) begin
                    acc = 0;
                    for (int k = 0; k < SH_TERMS; k++)
                        acc += longint'(probe_coef[probe*SH_TERMS + k][c]) * basis[k];
                    val[i][c] = rnd(acc, 16);
                end
            end
            for (int c = 0; c < 3; c++) begin
                for (int j = 0; j < 4; j++)
                    blend[j] = lerp(val[2*j][c], val[2*j+1][c], frac[0]);
                y0  = lerp(blend[0], blend[1], frac[1]);
                y1  = lerp(blend[2], blend[3], frac[1]);
                res = lerp(y0, y1, frac[2]);
                if (res > 64'sd2147483647) res = 64'sd2147483647;
                if (res < -64'sd2147483648) res = -64'sd2147483648;
                lt.rgb[c] = res[31:0];
            end
            pending.push_back(lt);
        endfunction

        function void check_light(logic signed [COEF_W-1:0] r, logic signed [COEF_W-1:0] g,
                                  logic signed [COEF_W-1:0] b);
            t_light want;
            if (pending.size() == 0) begin
                $error("light result arrived with no sample pending");
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (r !== want.rgb[0]) begin
                $error("light_red: expected %0d, got %0d", want.rgb[0], r);
                errors++;
            end
            if (g !== want.rgb[1]) begin
                $error("light_green: expected %0d, got %0d", want.rgb[1], g);
                errors++;
            end
            if (b !== want.rgb[2]) begin
                $error("light_blue: expected %0d, got %0d", want.rgb[2], b);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic                     i_opcode = 1'b0;
    logic [PN_W-1:0]          i_probe_number = '0;
    logic [TERM_W-1:0]        i_band_term = '0;
    logic signed [COEF_W-1:0] i_coef_red = '0;
    logic signed [COEF_W-1:0] i_coef_green = '0;
    logic signed [COEF_W-1:0] i_coef_blue = '0;
    logic signed [POS_W-1:0]  i_sample_x = '0;
    logic signed [POS_W-1:0]  i_sample_y = '0;
    logic signed [POS_W-1:0]  i_sample_z = '0;
    logic signed [DIR_W-1:0]  i_dir_x = '0;
    logic signed [DIR_W-1:0]  i_dir_y = '0;
    logic signed [DIR_W-1:0]  i_dir_z = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [COEF_W-1:0] o_light_red;
    logic signed [COEF_W-1:0] o_light_green;
    logic signed [COEF_W-1:0] o_light_blue;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]         i_cfg_data = '0;

    t_irradiance_book book = new();
    bit quiet    = 1'b0;  // no idling on either side while set
    bit hold_req = 1'b0;  // asks the receiver for one long stall

    sh_probe_grid_trilinear_sampler dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: random back-pressure, one long hold-off on request, and the
    // check of every result taken at a rising edge.
    initial begin
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                book.check_light(o_light_red, o_light_green, o_light_blue);
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge i_clk);
                    @(negedge i_clk);
                end
            end
            i_out_ready <= quiet || ($urandom_range(99) >= 30);
        end
    end

    // Watchdog: ends the run when neither channel has moved for too long.
    initial begin
        int stuck;
        stuck = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stuck = 0;
            else stuck++;
            if (stuck >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("sh_probe_grid_trilinear_sampler regression: fail");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    // Valid is left high so back-to-back requests never toggle it within a step.
    task automatic send(t_grid_req r);
        if (!quiet && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_opcode       <= r.op;
        i_probe_number <= r.pn;
        i_band_term    <= r.term;
        i_coef_red     <= r.coef[0];
        i_coef_green   <= r.coef[1];
        i_coef_blue    <= r.coef[2];
        i_sample_x     <= r.pos[0];
        i_sample_y     <= r.pos[1];
        i_sample_z     <= r.pos[2];
        i_dir_x        <= r.dir[0];
        i_dir_y        <= r.dir[1];
        i_dir_z        <= r.dir[2];
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        book.note_request(r);
        @(negedge i_clk);
    endtask

    // Waits until every sample has returned, then lets the block settle, and
    // writes all six grid registers in consecutive cycles.
    task automatic set_grid(logic [CFG_W-1:0] org [3], logic [CFG_W-1:0] csz [3]);
        i_in_valid <= 1'b0;
        while (book.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        for (int idx = 0; idx < 6; idx++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(idx);
            i_cfg_data  <= (idx < 3) ? org[idx] : csz[idx-3];
            book.set_grid(idx, (idx < 3) ? org[idx] : csz[idx-3]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Fields that a request does not use are filled with random bits.
    function automatic t_grid_req noise_req();
        t_grid_req r;
        r.op   = 1'($urandom);
        r.pn   = PN_W'($urandom);
        r.term = TERM_W'($urandom);
        for (int a = 0; a < 3; a++) begin
            r.coef[a] = $urandom;
            r.pos[a]  = $urandom;
            r.dir[a]  = DIR_W'($urandom);
        end
        return r;
    endfunction

    function automatic t_grid_req write_req(int pn, int term, int cr, int cg, int cb);
        t_grid_req r;
        r         = noise_req();
        r.op      = OP_WRITE;
        r.pn      = PN_W'(pn);
        r.term    = TERM_W'(term);
        r.coef[0] = cr;
        r.coef[1] = cg;
        r.coef[2] = cb;
        return r;
    endfunction

    function automatic t_grid_req sample_req(int px, int py, int pz, int dx, int dy, int dz);
        t_grid_req r;
        r        = noise_req();
        r.op     = OP_SAMPLE;
        r.pos[0] = px;
        r.pos[1] = py;
        r.pos[2] = pz;
        r.dir[0] = DIR_W'(dx);
        r.dir[1] = DIR_W'(dy);
        r.dir[2] = DIR_W'(dz);
        return r;
    endfunction

    function automatic int rand_coef();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return $signed($urandom_range(0, 2097152)) - 1048576;
        if (pick < 90) return $urandom;
        return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    endfunction

    function automatic int rand_dir();
        if ($urandom_range(99) < 80) return $signed($urandom_range(0, 32768)) - 16384;
        return $signed(16'($urandom));
    endfunction

    // Writes usually land in a small corner of the grid where most samples
    // fall, so that samples blend probes that actually hold data.
    function automatic t_grid_req random_req();
        t_grid_req r;
        longint    g, csize, pos;
        r = noise_req();
        if ($urandom_range(1)) begin
            r.op = OP_WRITE;
            if ($urandom_range(99) < 70)
                r.pn = PN_W'($urandom_range(2) * RES_X * RES_Y + $urandom_range(2) * RES_X
                             + $urandom_range(2));
            if ($urandom_range(99) < 90) r.term = TERM_W'($urandom_range(SH_TERMS - 1));
            for (int c = 0; c < 3; c++) r.coef[c] = rand_coef();
        end else begin
            r.op = OP_SAMPLE;
            for (int a = 0; a < 3; a++) begin
                r.dir[a] = DIR_W'(rand_dir());
                if ($urandom_range(99) < 80) begin
                    if ($urandom_range(99) < 70) g = longint'($urandom_range(0, 3 * 65536));
                    else g = longint'($urandom_range(0, 10 * 65536)) - 65536;
                    csize    = (book.cell_size[a] > 0) ? book.cell_size[a] : 65536;
                    pos      = book.origin[a] + g * csize / 65536;
                    r.pos[a] = pos[31:0];
                end
            end
        end
        return r;
    endfunction

    initial begin
        logic [CFG_W-1:0] org [3];
        logic [CFG_W-1:0] csz [3];
        int               big;
        int               low;
        big = 32'sh7fffffff;
        low = 32'sh80000000;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part on the reset grid. An empty store samples as zero.
        send(sample_req(65536, 65536, 65536, 16384, 0, 0));
        // Probe 0 loaded so that a normal of -2.0 on every axis drives all terms but
        // term 8, whose basis is zero, the same way and the result saturates high.
        send(write_req(0, 0, big, big, big));
        for (int k = 1; k <= 3; k++) send(write_req(0, k, low, low, low));
        for (int k = 4; k <= 8; k++) send(write_req(0, k, big, big, big));
        send(sample_req(0, 0, 0, -32768, -32768, -32768));
        // Unit normals on each axis and a far negative position clamped to probe 0.
        send(sample_req(32768, 16384, 0, 16384, 0, 0));
        send(sample_req(low, low, low, 0, -16384, 0));
        send(sample_req(0, 0, 0, 0, 0, 16384));
        // Last probe: term 0 at the most negative value in red, two writes with terms out
        // of range that must be ignored, then mixed terms for low saturation.
        send(write_req(PROBES - 1, 0, low, big, 1));
        send(write_req(PROBES - 1, 15, big, big, big));
        send(write_req(PROBES - 1, 9, big, low, big));
        for (int k = 4; k <= 7; k += 3) send(write_req(PROBES - 1, k, low, low, low));
        send(write_req(PROBES - 1, 5, low, low, low));
        send(sample_req(big, big, big, 0, 0, 0));
        send(sample_req(big, big, big, -32768, -32768, -32768));
        send(sample_req(7 * 65536 + 32768, 7 * 65536, big, 16384, 16384, 16384));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1: begin
                    org = '{-3 * 65536 - 32768, 2 * 65536 + 16384, 100 * 65536};
                    csz = '{2 * 65536, 32768, 3 * 65536};
                    set_grid(org, csz);
                end
                2: begin
                    // Non-positive cell sizes fall back to 1.0.
                    org = '{big, low, 0};
                    csz = '{0, low, -1};
                    set_grid(org, csz);
                end
                3: begin
                    org = '{$urandom, $urandom, $urandom};
                    csz = '{1, big, 98304};
                    set_grid(org, csz);
                end
                default: ;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                quiet = (phase == 2 && n < 200);
                if (phase == 1 && n == 100) hold_req = 1'b1;
                send(random_req());
            end
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        while (book.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d coefficient writes and %0d samples over four grid setups",
                 book.writes, book.samples);
        $display("%0d results checked, %0d mismatches", book.checked, book.errors);
        if (book.errors == 0) $display("sh_probe_grid_trilinear_sampler regression: pass");
        else $display("sh_probe_grid_trilinear_sampler regression: fail");
        $finish;
    end

endmodule
